@@ rtl/core/fbpa_pkg.sv @@
package fbpa_pkg;

    // Widths fixed by the item and register formats.
    localparam int DATA_W     = 32;
    localparam int BYTES_W    = 16;
    localparam int SIZE_W     = 17;
    localparam int COUNT_W    = 9;
    localparam int INDEX_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = COUNT_W + SIZE_W;

    // Width of the address space that block addresses wrap in.
    localparam int ADDRESS_BITS = 32;
    localparam logic [DATA_W-1:0] ADDR_MASK = (ADDRESS_BITS >= DATA_W) ? '1 :
        DATA_W'((64'd1 << ADDRESS_BITS) - 64'd1);

    // Default pool capacity.
    localparam int MAX_BLOCKS_DEF = 256;

    // Divider width and its step counter.
    localparam int DIV_W     = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Result status codes.
    typedef logic [2:0] t_status;
    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_EMPTY   = 3'd1;
    localparam t_status ST_RANGE   = 3'd2;
    localparam t_status ST_NOTBUSY = 3'd3;
    localparam t_status ST_CONFIG  = 3'd4;

    // Request actions.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BASE   = 2'd0;
    localparam t_cfg_idx CFG_BYTES  = 2'd1;
    localparam t_cfg_idx CFG_BLOCK  = 2'd2;
    localparam t_cfg_idx CFG_COUNT  = 2'd3;

    // Register values after reset.
    localparam logic [DATA_W-1:0]  RST_BASE  = '0;
    localparam logic [DATA_W-1:0]  RST_BYTES = '0;
    localparam logic [BYTES_W-1:0] RST_BLOCK = 16'd4;
    localparam logic [COUNT_W-1:0] RST_COUNT = '0;

endpackage

@@ rtl/core/fbpa_div.sv @@
module fbpa_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [fbpa_pkg::DIV_W-1:0]        i_dividend,
    input  logic [fbpa_pkg::SIZE_W-1:0]       i_divisor,
    output logic                              o_done,
    output logic [fbpa_pkg::DIV_W-1:0]        o_quotient,
    output logic [fbpa_pkg::SIZE_W-1:0]       o_remainder
);

    localparam int DW = fbpa_pkg::DIV_W;
    localparam int SW = fbpa_pkg::SIZE_W;
    localparam int CW = fbpa_pkg::DIV_CNT_W;

    logic          r_run;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [SW-1:0] r_rem;
    logic [SW:0]   partial;
    logic          fits;

    // One restoring step: bring down the next dividend bit and try the subtraction.
    assign partial = {r_rem, r_quo[DW-1]};
    assign fits    = partial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_quo <= i_dividend;
                r_rem <= '0;
            end else if (r_run) begin
                r_quo <= {r_quo[DW-2:0], fits};
                r_rem <= fits ? SW'(partial - {1'b0, i_divisor}) : SW'(partial);
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ rtl/core/fixed_block_pool_allocator_core.sv @@
// Channel   | Direction | Handshake               | Payload
// input     | in        | i_in_valid / o_in_stall | i_in_action, i_in_address
// output    | out       | o_out_valid/i_out_stall | o_out_status, o_out_block_address,
//           |           |                         | o_out_block_index
// config    | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// An allocate runs the limit, decide, address and sum states (plus pop when it reuses a
// freed block); a free waits on the 32-step restoring divider that finds the block index.
// One request is in progress at a time; the next may be taken while a result waits.
// Reset is synchronous and active low; there is no clearing pass after it.
// A stalled result holds the sequencer in its final state until the result is taken.
module fixed_block_pool_allocator_core #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_in_action,
    input  logic [fbpa_pkg::DATA_W-1:0]        i_in_address,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_out_status,
    output logic [fbpa_pkg::DATA_W-1:0]        o_out_block_address,
    output logic [fbpa_pkg::INDEX_W-1:0]       o_out_block_index,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fbpa_pkg::DATA_W-1:0]        i_cfg_data
);

    localparam int IW  = $clog2(MAX_BLOCKS);
    localparam int DPW = $clog2(MAX_BLOCKS + 1);
    localparam int AW  = fbpa_pkg::DATA_W;
    localparam int SW  = fbpa_pkg::SIZE_W;
    localparam int CW  = fbpa_pkg::COUNT_W;
    localparam int PW  = fbpa_pkg::PROD_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LIMIT  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_POP    = 3'd3;
    localparam logic [2:0] S_ADDR   = 3'd4;
    localparam logic [2:0] S_SUM    = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]                   r_state;
    logic [AW-1:0]                r_base;
    logic [AW-1:0]                r_region_bytes;
    logic [fbpa_pkg::BYTES_W-1:0] r_block_bytes;
    logic [CW-1:0]                r_block_count;
    logic [DPW-1:0]               r_depth;
    logic [CW-1:0]                r_never;
    logic [MAX_BLOCKS-1:0]        r_busy;
    logic [IW-1:0]                r_stack [MAX_BLOCKS];
    logic [IW-1:0]                r_stack_rd;
    logic                         r_req_action;
    logic [AW-1:0]                r_req_addr;
    logic [PW-1:0]                r_prod;
    logic [IW-1:0]                r_idx;
    logic [AW-1:0]                r_blk_addr;
    fbpa_pkg::t_status            r_status;
    logic                         r_out_valid;
    fbpa_pkg::t_status            r_out_status;
    logic [AW-1:0]                r_out_addr;
    logic [fbpa_pkg::INDEX_W-1:0] r_out_idx;

    logic [SW-1:0]  size;
    logic [CW-1:0]  mul_a;
    logic [PW-1:0]  prod;
    logic           usable;
    logic [AW-1:0]  offset;
    logic           below_base;
    logic           past_end;
    logic           div_start;
    logic           div_done;
    logic [AW-1:0]  div_quo;
    logic [SW-1:0]  div_rem;
    logic [IW-1:0]  q_idx;
    logic [IW-1:0]  never_idx;
    logic [IW-1:0]  pop_addr;
    logic           push_en;
    logic           cfg_wr;

    // Rounded block size and the shared multiplier for the pool limit and block addresses.
    always_comb begin
        size  = (SW'(r_block_bytes) + SW'(3)) & ~SW'(3);
        mul_a = (r_state == S_ADDR) ? CW'(r_idx) : r_block_count;
        prod  = PW'(mul_a) * PW'(size);
    end

    // Checks on the configuration and on the address of a free request.
    always_comb begin
        usable     = (size != '0) && (32'(r_block_count) <= 32'(MAX_BLOCKS))
                     && (AW'(r_prod) <= r_region_bytes);
        offset     = r_req_addr - r_base;
        below_base = r_req_addr < r_base;
        past_end   = offset >= AW'(r_prod);
        div_start  = (r_state == S_DECIDE) && usable && (r_req_action == fbpa_pkg::ACT_FREE)
                     && !below_base && !past_end;
        q_idx      = IW'(div_quo);
        never_idx  = IW'(r_never - CW'(1));
        pop_addr   = IW'(r_depth - DPW'(1));
        push_en    = (r_state == S_DIV) && div_done && r_busy[q_idx]
                     && (r_depth < DPW'(MAX_BLOCKS));
        cfg_wr     = i_cfg_valid && o_cfg_ready;
    end

    fbpa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (offset),
        .i_divisor   (size),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Freed-block stack, read every cycle at the current top.
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_stack[IW'(r_depth)] <= q_idx;
        end
        r_stack_rd <= r_stack[pop_addr];
    end

    // Sequencer, pool bookkeeping and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_base         <= fbpa_pkg::RST_BASE;
            r_region_bytes <= fbpa_pkg::RST_BYTES;
            r_block_bytes  <= fbpa_pkg::RST_BLOCK;
            r_block_count  <= fbpa_pkg::RST_COUNT;
            r_depth        <= '0;
            r_never        <= fbpa_pkg::RST_COUNT;
            r_busy         <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        r_req_action <= i_in_action;
                        r_req_addr   <= i_in_address;
                        r_state      <= S_LIMIT;
                    end
                end
                S_LIMIT: begin
                    r_prod  <= prod;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (!usable) begin
                        r_status <= fbpa_pkg::ST_CONFIG;
                        r_state  <= S_DONE;
                    end else if (r_req_action == fbpa_pkg::ACT_ALLOC) begin
                        if (r_depth != '0) begin
                            r_depth <= r_depth - DPW'(1);
                            r_state <= S_POP;
                        end else if (r_never != '0) begin
                            r_never           <= r_never - CW'(1);
                            r_idx             <= never_idx;
                            r_busy[never_idx] <= 1'b1;
                            r_state           <= S_ADDR;
                        end else begin
                            r_status <= fbpa_pkg::ST_EMPTY;
                            r_state  <= S_DONE;
                        end
                    end else if (below_base || past_end) begin
                        r_status <= fbpa_pkg::ST_RANGE;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_POP: begin
                    r_idx              <= r_stack_rd;
                    r_busy[r_stack_rd] <= 1'b1;
                    r_state            <= S_ADDR;
                end
                S_ADDR: begin
                    r_prod  <= prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_blk_addr <= r_base + AW'(r_prod);
                    r_status   <= fbpa_pkg::ST_OK;
                    r_state    <= S_DONE;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (!r_busy[q_idx]) begin
                            r_status <= fbpa_pkg::ST_NOTBUSY;
                        end else begin
                            r_busy[q_idx] <= 1'b0;
                            if (r_depth < DPW'(MAX_BLOCKS)) begin
                                r_depth <= r_depth + DPW'(1);
                            end
                            r_idx      <= q_idx;
                            r_blk_addr <= r_req_addr - AW'(div_rem);
                            r_status   <= fbpa_pkg::ST_OK;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        if (r_status == fbpa_pkg::ST_OK) begin
                            r_out_addr <= r_blk_addr & fbpa_pkg::ADDR_MASK;
                            r_out_idx  <= fbpa_pkg::INDEX_W'(r_idx);
                        end else begin
                            r_out_addr <= '0;
                            r_out_idx  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // A register write frees every block.
            if (cfg_wr) begin
                case (i_cfg_index)
                    fbpa_pkg::CFG_BASE:  r_base         <= i_cfg_data;
                    fbpa_pkg::CFG_BYTES: r_region_bytes <= i_cfg_data;
                    fbpa_pkg::CFG_BLOCK: r_block_bytes  <= i_cfg_data[fbpa_pkg::BYTES_W-1:0];
                    fbpa_pkg::CFG_COUNT: r_block_count  <= i_cfg_data[CW-1:0];
                    default:             r_base         <= r_base;
                endcase
                r_depth <= '0;
                r_never <= (i_cfg_index == fbpa_pkg::CFG_COUNT) ? i_cfg_data[CW-1:0]
                                                                : r_block_count;
                r_busy  <= '0;
            end
        end
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_cfg_ready         = 1'b1;
    assign o_out_valid         = r_out_valid;
    assign o_out_status        = r_out_status;
    assign o_out_block_address = r_out_addr;
    assign o_out_block_index   = r_out_idx;

endmodule

@@ rtl/core/fbpa_chk.sv @@
module fbpa_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [2:0]                         o_out_status,
    input logic [fbpa_pkg::DATA_W-1:0]        o_out_block_address,
    input logic [fbpa_pkg::INDEX_W-1:0]       o_out_block_index
);

    // Once a request is taken, no further request is taken until it has finished.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while another is in progress");

    // A new result only appears at the end of a request's work.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in progress");

    // An error result carries neither address nor index.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_status != fbpa_pkg::ST_OK))
        |-> (o_out_block_address == '0) && (o_out_block_index == '0))
        else $error("error result with non-zero payload");

    // A pending result is held until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_out_status)
        && $stable(o_out_block_address) && $stable(o_out_block_index))
        else $error("stalled result changed or was dropped");

endmodule

bind fixed_block_pool_allocator_core fbpa_chk u_fbpa_chk (.*);
